// ----- hw/rtl/step_sequencer_accent_slide_top_macros.svh -----
// ----------------------------------------------------------------------------
// step_sequencer_accent_slide_top_macros.svh
// Assertion shorthands for the step sequencer. Each one uses clk_i and
// rst_ni of the module that includes this file.
// ----------------------------------------------------------------------------
`ifndef STEP_SEQUENCER_ACCENT_SLIDE_TOP_MACROS_SVH
`define STEP_SEQUENCER_ACCENT_SLIDE_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SSAS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sequencer check failed");

// Next-cycle implication, checked outside reset.
`define SSAS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sequencer check failed");

`endif

// ----- hw/rtl/ssas_pkg.sv -----
// ----------------------------------------------------------------------------
// ssas_pkg
// Shared types, command and event codes and constants of the step sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package ssas_pkg;

  // Storage depth default
  localparam int unsigned MAX_STEPS_DEF = 128;

  // Field widths
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned NOTE_W     = 8;
  localparam int unsigned VEL_W      = 7;
  localparam int unsigned BEND_W     = 14;
  localparam int unsigned PPS_W      = 3;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 32;

  // Input commands
  localparam logic [CMD_W-1:0] CMD_CLOCK      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_NOTE_ON    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_WHEEL      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_BEND       = 3'd3;
  localparam logic [CMD_W-1:0] CMD_START_PLAY = 3'd4;
  localparam logic [CMD_W-1:0] CMD_STOP_PLAY  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_START_REC  = 3'd6;
  localparam logic [CMD_W-1:0] CMD_STOP_REC   = 3'd7;

  // Output event kinds
  localparam logic [KIND_W-1:0] EV_VOICE_ON  = 2'd0;
  localparam logic [KIND_W-1:0] EV_VOICE_OFF = 2'd1;
  localparam logic [KIND_W-1:0] EV_MIDI_ON   = 2'd2;
  localparam logic [KIND_W-1:0] EV_MIDI_OFF  = 2'd3;

  // Stored note codes
  localparam logic [NOTE_W-1:0] NOTE_REST = 8'hFF;
  localparam logic [NOTE_W-1:0] NOTE_TIE  = 8'hFE;

  // Amounts and thresholds
  localparam logic [VEL_W-1:0]  GLIDE_SLID     = 7'h60;
  localparam logic [VEL_W-1:0]  ACCENT_ON      = 7'h70;
  localparam logic [VEL_W-1:0]  VEL_MAX        = 7'h7F;
  localparam logic [VEL_W-1:0]  VEL_DEFAULT    = 7'h40;
  localparam logic [VEL_W-1:0]  WHEEL_THRESH   = 7'h40;
  localparam logic [VEL_W-1:0]  NOTE_MAX       = 7'd127;
  localparam logic [BEND_W-1:0] BEND_LO        = 14'd6144;
  localparam logic [BEND_W-1:0] BEND_HI        = 14'd10240;
  localparam logic signed [8:0] TRANSPOSE_BASE = 9'sd60;
  localparam logic signed [8:0] OFFSET_MAX9    = 9'sd127;
  localparam logic signed [7:0] OFFSET_MAX     = 8'sd127;
  localparam logic signed [9:0] SUM_NOTE_MAX   = 10'sd127;
  localparam logic [PPS_W-1:0]  PPS_RESET      = 3'd1;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [VEL_W-1:0]  note;
    logic [VEL_W-1:0]  velocity;
    logic [VEL_W-1:0]  glide;
    logic [VEL_W-1:0]  accent;
    logic              legato;
  } event_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
    logic pop;
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic has_events;
    logic at_last;
  } sts_t;

  function automatic event_t make_ev(input logic [KIND_W-1:0] kind,
                                     input logic [VEL_W-1:0] note,
                                     input logic [VEL_W-1:0] velocity,
                                     input logic [VEL_W-1:0] glide,
                                     input logic [VEL_W-1:0] accent,
                                     input logic legato);
    event_t ev;
    ev.kind     = kind;
    ev.note     = note;
    ev.velocity = velocity;
    ev.glide    = glide;
    ev.accent   = accent;
    ev.legato   = legato;
    return ev;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ssas_ram.sv -----
// ----------------------------------------------------------------------------
// ssas_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ssas_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ssas_ctrl.sv -----
// ----------------------------------------------------------------------------
// ssas_ctrl
// Sequencer controller: accept one item, execute it, hand out its events.
// ----------------------------------------------------------------------------
`default_nettype none

module ssas_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  input  wire ssas_pkg::sts_t  sts_i,
  output ssas_pkg::ctl_t       ctl_o
);
  import ssas_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    ctl_o       = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctl_o.exec = 1'b1;
        state_d    = sts_i.has_events ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          ctl_o.pop = 1'b1;
          if (sts_i.at_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ssas_dp.sv -----
// ----------------------------------------------------------------------------
// ssas_dp
// Sequencer datapath: note store, accent and slide bits, play state and the
// event buffer of the item in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module ssas_dp #(
  parameter int unsigned MAX_STEPS = ssas_pkg::MAX_STEPS_DEF,
  localparam int unsigned AW       = $clog2(MAX_STEPS),
  localparam int unsigned CW       = $clog2(MAX_STEPS + 1)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire ssas_pkg::ctl_t               ctl_i,
  output ssas_pkg::sts_t                    sts_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [ssas_pkg::PPS_W-1:0]   cfg_data_i,
  input  wire logic [ssas_pkg::CMD_W-1:0]   in_cmd_i,
  input  wire logic [ssas_pkg::NOTE_W-1:0]  in_note_i,
  input  wire logic [ssas_pkg::VEL_W-1:0]   in_vel_i,
  input  wire logic [ssas_pkg::VEL_W-1:0]   in_wheel_i,
  input  wire logic [ssas_pkg::BEND_W-1:0]  in_bend_i,
  output ssas_pkg::event_t                  ev_o,
  output logic                              ev_last_o
);
  import ssas_pkg::*;

  localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_STEPS);

  // Configuration
  logic [PPS_W-1:0] pps_q;

  // Latched item
  logic [CMD_W-1:0]  cmd_q;
  logic [NOTE_W-1:0] note_q;
  logic [VEL_W-1:0]  vel_q;
  logic [VEL_W-1:0]  wheel_q;
  logic [BEND_W-1:0] bend_q;

  // Sequencer state
  logic [MAX_STEPS-1:0] accent_q, accent_d;
  logic [MAX_STEPS-1:0] slide_q, slide_d;
  logic [CW-1:0]        count_q, count_d;
  logic [AW-1:0]        pos_q, pos_d;
  logic [PPS_W-1:0]     pulse_q, pulse_d;
  logic                 playing_q, playing_d;
  logic                 rec_q, rec_d;
  logic signed [7:0]    offset_q, offset_d;
  logic [VEL_W-1:0]     pvel_q, pvel_d;
  logic                 prev_valid_q, prev_valid_d;
  logic [VEL_W-1:0]     prev_note_q, prev_note_d;

  // Event buffer
  event_t     ev_q [3];
  event_t     ev_d [3];
  logic [1:0] ev_n_q, ev_n_d;
  logic [1:0] ev_idx_q, ev_idx_d;

  // Execute helpers
  logic [NOTE_W-1:0] stored;
  logic              stop_req;
  logic              wr_en;
  logic [1:0]        n;
  logic [PPS_W-1:0]  div;
  logic [PPS_W-1:0]  pulse_inc;
  logic signed [9:0] tsum;
  logic [VEL_W-1:0]  tnote;
  logic              slid;
  logic              acc;
  logic [CW-1:0]     pos_ext;
  logic [CW-1:0]     count_inc;
  logic signed [8:0] tdiff;
  logic              count_room;

  ssas_ram #(
    .WIDTH(NOTE_W),
    .DEPTH(MAX_STEPS)
  ) u_note_store (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(count_q[AW-1:0]),
    .wdata_i(note_q),
    .re_i   (ctl_i.load),
    .raddr_i(pos_q),
    .rdata_o(stored)
  );

  // Stop playback and release the sounding note for these commands; start play does so only while recording.
  always_comb begin
    case (cmd_q)
      CMD_STOP_PLAY, CMD_START_REC, CMD_STOP_REC: stop_req = 1'b1;
      CMD_START_PLAY:                             stop_req = rec_q;
      default:                                    stop_req = 1'b0;
    endcase
  end

  assign div        = (pps_q == '0) ? PPS_W'(1) : pps_q;
  assign pulse_inc  = pulse_q + PPS_W'(1);
  assign tsum       = $signed({2'b00, stored}) + $signed({{2{offset_q[7]}}, offset_q});
  assign tnote      = tsum[9] ? '0 : ((tsum > SUM_NOTE_MAX) ? NOTE_MAX : tsum[6:0]);
  assign slid       = slide_q[pos_q];
  assign acc        = accent_q[pos_q];
  assign pos_ext    = CW'(pos_q) + CW'(1);
  assign count_inc  = count_q + CW'(1);
  assign tdiff      = $signed({1'b0, note_q}) - TRANSPOSE_BASE;
  assign count_room = (count_q < COUNT_MAX);

  always_comb begin
    accent_d     = accent_q;
    slide_d      = slide_q;
    count_d      = count_q;
    pos_d        = pos_q;
    pulse_d      = pulse_q;
    playing_d    = playing_q;
    rec_d        = rec_q;
    offset_d     = offset_q;
    pvel_d       = pvel_q;
    prev_valid_d = prev_valid_q;
    prev_note_d  = prev_note_q;
    ev_d         = ev_q;
    ev_n_d       = ev_n_q;
    ev_idx_d     = ev_idx_q;
    wr_en        = 1'b0;
    n            = '0;

    if (ctl_i.load) begin
      ev_idx_d = '0;
    end

    if (ctl_i.pop) begin
      ev_idx_d = ev_idx_q + 2'd1;
    end

    if (ctl_i.exec) begin
      // Release the sounding note first; start play re-arms playback below.
      if (stop_req) begin
        if (prev_valid_q) begin
          ev_d[n] = make_ev(EV_VOICE_OFF, prev_note_q, '0, '0, '0, 1'b0);
          n       = n + 2'd1;
          ev_d[n] = make_ev(EV_MIDI_OFF, prev_note_q, '0, '0, '0, 1'b0);
          n       = n + 2'd1;
        end
        prev_valid_d = 1'b0;
        playing_d    = 1'b0;
      end

      case (cmd_q)
        CMD_CLOCK: begin
          if (pulse_q == '0 && playing_q && count_q != '0) begin
            if (stored == NOTE_REST) begin
              if (prev_valid_q) begin
                ev_d[n] = make_ev(EV_VOICE_OFF, prev_note_q, '0, '0, '0, 1'b0);
                n       = n + 2'd1;
                ev_d[n] = make_ev(EV_MIDI_OFF, prev_note_q, '0, '0, '0, 1'b0);
                n       = n + 2'd1;
              end
              prev_valid_d = 1'b0;
            end else if (stored != NOTE_TIE) begin
              if (!slid && prev_valid_q) begin
                ev_d[n] = make_ev(EV_MIDI_OFF, prev_note_q, '0, '0, '0, 1'b0);
                n       = n + 2'd1;
              end
              ev_d[n] = make_ev(EV_VOICE_ON, tnote, pvel_q,
                                slid ? GLIDE_SLID : '0, acc ? ACCENT_ON : '0, slid);
              n       = n + 2'd1;
              ev_d[n] = make_ev(EV_MIDI_ON, tnote, acc ? VEL_MAX : pvel_q,
                                '0, '0, 1'b0);
              n       = n + 2'd1;
              if (slid && prev_valid_q) begin
                ev_d[n] = make_ev(EV_MIDI_OFF, prev_note_q, '0, '0, '0, 1'b0);
                n       = n + 2'd1;
              end
              prev_valid_d = 1'b1;
              prev_note_d  = tnote;
            end
            // Advance and wrap at the recorded length.
            pos_d = (pos_ext >= count_q) ? '0 : pos_ext[AW-1:0];
          end
          pulse_d = (pulse_inc >= div) ? '0 : pulse_inc;
        end
        CMD_NOTE_ON: begin
          if (vel_q != '0) begin
            if (playing_q && count_q != '0) begin
              offset_d = (tdiff > OFFSET_MAX9) ? OFFSET_MAX : tdiff[7:0];
              pvel_d   = vel_q;
            end
            if (rec_q) begin
              if (count_room) begin
                wr_en   = 1'b1;
                count_d = count_inc;
                if (count_inc >= COUNT_MAX) begin
                  rec_d = 1'b0;
                end
              end else begin
                rec_d = 1'b0;
              end
            end
          end
        end
        CMD_WHEEL: begin
          if (rec_q && wheel_q > WHEEL_THRESH && count_room) begin
            accent_d[count_q[AW-1:0]] = 1'b1;
          end
        end
        CMD_BEND: begin
          if (rec_q && !(bend_q inside {[BEND_LO:BEND_HI]}) && count_room) begin
            slide_d[count_q[AW-1:0]] = 1'b1;
          end
        end
        CMD_START_PLAY: begin
          if (rec_q) begin
            rec_d    = 1'b0;
            offset_d = '0;
            pvel_d   = VEL_DEFAULT;
          end
          pos_d     = '0;
          playing_d = 1'b1;
        end
        CMD_STOP_PLAY: begin
          // Release handled above.
        end
        CMD_START_REC: begin
          rec_d    = 1'b1;
          accent_d = '0;
          slide_d  = '0;
          count_d  = '0;
        end
        default: begin
          rec_d    = 1'b0;
          offset_d = '0;
          pvel_d   = VEL_DEFAULT;
        end
      endcase

      ev_n_d = n;
    end
  end

  assign sts_o.has_events = (n != '0);
  assign sts_o.at_last    = (ev_idx_q == ev_n_q - 2'd1);
  assign ev_o             = ev_q[ev_idx_q];
  assign ev_last_o        = sts_o.at_last;

  // Payload: latched item and event buffer
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q   <= in_cmd_i;
      note_q  <= in_note_i;
      vel_q   <= in_vel_i;
      wheel_q <= in_wheel_i;
      bend_q  <= in_bend_i;
    end
    ev_q <= ev_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pps_q        <= PPS_RESET;
      accent_q     <= '0;
      slide_q      <= '0;
      count_q      <= '0;
      pos_q        <= '0;
      pulse_q      <= '0;
      playing_q    <= 1'b0;
      rec_q        <= 1'b0;
      offset_q     <= '0;
      pvel_q       <= VEL_DEFAULT;
      prev_valid_q <= 1'b0;
      prev_note_q  <= '0;
      ev_n_q       <= '0;
      ev_idx_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        pps_q <= cfg_data_i;
      end
      accent_q     <= accent_d;
      slide_q      <= slide_d;
      count_q      <= count_d;
      pos_q        <= pos_d;
      pulse_q      <= pulse_d;
      playing_q    <= playing_d;
      rec_q        <= rec_d;
      offset_q     <= offset_d;
      pvel_q       <= pvel_d;
      prev_valid_q <= prev_valid_d;
      prev_note_q  <= prev_note_d;
      ev_n_q       <= ev_n_d;
      ev_idx_q     <= ev_idx_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/step_sequencer_accent_slide_top.sv -----
// ----------------------------------------------------------------------------
// step_sequencer_accent_slide_top
// Monophonic record/playback step sequencer with accent and slide per step.
//
// Each input transfer carries one MIDI-like command (clock pulse, note on,
// mod wheel, pitch bend, start/stop play, start/stop record). An item is
// executed in an accept cycle, which also launches the registered read of
// the note store at the play position, and an execute cycle that
// consumes that read data and updates the sequencer state. The item then
// yields zero to three event transfers, one per cycle while the output is
// ready, the final one flagged by tlast; the next input is taken only after
// the last event of the current one has gone out. The note store is a RAM
// of MAX_STEPS entries that needs no clearing after reset; the accent and
// slide bits are flip-flops cleared by reset and by start record.
// Transposed notes clamp to 0..127. pulses_per_step is written through the
// cfg port, which is always ready; a value of zero acts as one.
// ----------------------------------------------------------------------------
`default_nettype none
`include "step_sequencer_accent_slide_top_macros.svh"

module step_sequencer_accent_slide_top #(
  parameter int unsigned MAX_STEPS = ssas_pkg::MAX_STEPS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Configuration: pulses_per_step
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [ssas_pkg::PPS_W-1:0]          cfg_data_i,
  // Input commands
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // note_value [7:0], note_velocity [14:8], wheel_value [21:15],
  // bend_value [35:22], zero [39:36]
  input  wire logic [ssas_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // cmd [2:0]
  input  wire logic [ssas_pkg::CMD_W-1:0]          s_axis_tuser,
  // Output events
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // out_note [6:0], out_velocity [13:7], glide_amount [20:14],
  // accent_amount [27:21], legato [28], zero [31:29]
  output logic      [ssas_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // event_kind [1:0]
  output logic      [ssas_pkg::KIND_W-1:0]         m_axis_tuser,
  output logic                                     m_axis_tlast
);
  import ssas_pkg::*;

  ctl_t   ctl;
  sts_t   sts;
  event_t ev;
  logic   ev_last;

  // Always ready: the user must send configuration writes only while idle.
  assign cfg_ready_o = 1'b1;

  ssas_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  ssas_dp #(
    .MAX_STEPS(MAX_STEPS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .sts_o     (sts),
    .cfg_we_i  (cfg_valid_i & cfg_ready_o),
    .cfg_data_i(cfg_data_i),
    .in_cmd_i  (s_axis_tuser),
    .in_note_i (s_axis_tdata[7:0]),
    .in_vel_i  (s_axis_tdata[14:8]),
    .in_wheel_i(s_axis_tdata[21:15]),
    .in_bend_i (s_axis_tdata[35:22]),
    .ev_o      (ev),
    .ev_last_o (ev_last)
  );

  // Pack the current event onto the output bus.
  assign m_axis_tuser = ev.kind;
  assign m_axis_tdata = {3'b000, ev.legato, ev.accent, ev.glide, ev.velocity, ev.note};
  assign m_axis_tlast = ev_last;

  // Never take an input while events of the previous one are still pending.
  `SSAS_ASSERT_IMPL(a_no_overlap, s_axis_tready, !m_axis_tvalid)
  // An event run continues until the event flagged last has gone out.
  `SSAS_ASSERT_NEXT(a_run_continues, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid)
  // The cycle after an accepted item is the execute cycle: both sides quiet.
  `SSAS_ASSERT_NEXT(a_exec_cycle, s_axis_tvalid && s_axis_tready, !s_axis_tready && !m_axis_tvalid)

endmodule

`default_nettype wire
